@@ src/murmur64a_hash_assert.svh @@
// ---------------------------------------------------------------------------
// murmur64a_hash_assert.svh
// Assertion macros shared by the murmur64a_hash block.
// ---------------------------------------------------------------------------
`ifndef MURMUR64A_HASH_ASSERT_SVH
`define MURMUR64A_HASH_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MM64_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MM64_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mm64_pkg.sv @@
// ---------------------------------------------------------------------------
// mm64_pkg
// Constants and shared types of the MurmurHash64A block.
// ---------------------------------------------------------------------------
package mm64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hC6A4_A793_5BD1_E995;
  localparam logic [31:0] MUL_LO    = MIX_MUL[31:0];
  localparam logic [31:0] MUL_HI    = MIX_MUL[63:32];
  localparam int unsigned MIX_SHIFT = 47;

  // config port: one 64-bit register per 8-byte slot
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic        REG_SEED   = 1'b0;

  typedef struct packed {
    logic        go;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    xorshift = v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

@@ src/mm64_if.sv @@
// ---------------------------------------------------------------------------
// mm64_if
// Valid/ready channels for message words in and hash words out.
// ---------------------------------------------------------------------------
interface mm64_in_if;
  logic        valid;
  logic        ready;
  logic        start_flag;
  logic [31:0] message_length;
  logic [63:0] data_word;

  modport source (output valid, start_flag, message_length, data_word, input ready);
  modport sink   (input valid, start_flag, message_length, data_word, output ready);
endinterface

interface mm64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

@@ src/mm64_mul.sv @@
// ---------------------------------------------------------------------------
// mm64_mul
// Multi-cycle 64-bit multiply by the mix constant, modulo 2^64, built from
// three 32x32 partial products on one multiplier.
// ---------------------------------------------------------------------------
module mm64_mul
  import mm64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0] a_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;

  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pp;

  // lo*lo, then the two cross terms; hi*hi falls off the top
  always_comb begin
    case (cnt_r)
      2'd0:    begin mx = a_r[31:0];  my = MUL_LO; end
      2'd1:    begin mx = a_r[31:0];  my = MUL_HI; end
      default: begin mx = a_r[63:32]; my = MUL_LO; end
    endcase
  end

  assign pp = 64'(mx) * 64'(my);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        a_r    <= req.operand;
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r  <= cnt_r + 2'd1;
        prod_r <= pp;
        case (cnt_r)
          2'd0: ;
          2'd1: acc_r <= prod_r;
          default: acc_r <= acc_r + {prod_r[31:0], 32'h0};
        endcase
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy    = busy_r;
  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

@@ src/mm64_cfg.sv @@
// ---------------------------------------------------------------------------
// mm64_cfg
// APB-style register port holding the 64-bit seed.
// ---------------------------------------------------------------------------
module mm64_cfg
  import mm64_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  output logic [63:0]           seed
);

  logic [63:0] seed_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'h0;
    end else if (wr_en && (paddr[3] == REG_SEED)) begin
      seed_r <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_SEED: prdata = seed_r;
      default:  prdata = 64'h0;
    endcase
  end

  assign seed = seed_r;

endmodule

@@ src/murmur64a_hash.sv @@
// ---------------------------------------------------------------------------
// murmur64a_hash
// Streaming MurmurHash64A over little-endian 64-bit message words.
// ---------------------------------------------------------------------------
// Every multiply by the mix constant goes through one shared unit that forms
// three 32x32 partial products between issue and result. A start word
// issues the length multiply before its data, a full word takes three
// multiplies, a partial last word one, and the finalizer adds one more on
// the word that ends a message; the result then sits in an output
// register while the next word is taken. A word outside a message is taken
// and dropped. The seed lives at byte address 0 of the register port;
// message lengths are taken modulo 2^LENGTH_BITS.
`include "murmur64a_hash_assert.svh"

module murmur64a_hash
  import mm64_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mm64_in_if.sink               in_word,
  mm64_out_if.source            out_hash,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int unsigned LEN_IN_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
  localparam logic [LENGTH_BITS-1:0] WORD_BYTES = LENGTH_BITS'(8);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN, ST_KMUL, ST_KMIX, ST_HMUL, ST_PART, ST_FIN, ST_HOLD
  } state_t;

  typedef struct packed {
    state_t      st;
    logic [63:0] opnd;
  } issue_t;

  state_t               state_r, state_nxt;
  logic                 go_r, go_nxt;
  logic [63:0]          opnd_r, opnd_nxt;
  logic [63:0]          h_r, h_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [63:0]          word_r, word_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [63:0]          hash_r, hash_nxt;

  logic [63:0]          seed;
  logic [LENGTH_BITS-1:0] len_in;
  logic                 in_acc;
  logic [63:0]          p;
  logic [63:0]          h_start;
  issue_t               nw;
  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;

  mm64_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed)
  );

  mm64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign mul_req.go      = go_r;
  assign mul_req.operand = opnd_r;

  // low rem bytes of the word, rem in 1..7
  function automatic logic [63:0] keep_low(input logic [63:0] w, input logic [2:0] rem);
    logic [63:0] r;
    r = 64'h0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < rem) r[8*i +: 8] = w[8*i +: 8];
    end
    keep_low = r;
  endfunction

  // first multiply of a data word: full word mixes k, partial word folds into h
  function automatic issue_t word_issue(input logic [63:0] h, input logic [63:0] w,
                                        input logic [LENGTH_BITS-1:0] rem);
    issue_t r;
    if (|rem[LENGTH_BITS-1:3]) begin
      r.st   = ST_KMUL;
      r.opnd = w;
    end else begin
      r.st   = ST_PART;
      r.opnd = h ^ keep_low(w, rem[2:0]);
    end
    word_issue = r;
  endfunction

  assign len_in  = LENGTH_BITS'(in_word.message_length[LEN_IN_W-1:0]);
  assign in_acc  = in_word.valid && in_word.ready;
  assign p       = mul_rsp.product;
  assign h_start = seed ^ p;

  always_comb begin
    if (state_r == ST_IDLE) nw = word_issue(h_r, in_word.data_word, rem_r);
    else                    nw = word_issue(h_start, word_r, rem_r);
  end

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    opnd_nxt      = opnd_r;
    h_nxt         = h_r;
    rem_nxt       = rem_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    hash_nxt      = hash_r;

    if (out_valid_r && out_hash.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          word_nxt = in_word.data_word;
          if (in_word.start_flag) begin
            rem_nxt   = len_in;
            state_nxt = ST_LEN;
            go_nxt    = 1'b1;
            opnd_nxt  = 64'(len_in);
          end else if (rem_r != '0) begin
            state_nxt = nw.st;
            go_nxt    = 1'b1;
            opnd_nxt  = nw.opnd;
          end
        end
      end
      ST_LEN: begin
        if (mul_rsp.done) begin
          h_nxt  = h_start;
          go_nxt = 1'b1;
          if (rem_r == '0) begin
            state_nxt = ST_FIN;
            opnd_nxt  = xorshift(h_start);
          end else begin
            state_nxt = nw.st;
            opnd_nxt  = nw.opnd;
          end
        end
      end
      ST_KMUL: begin
        if (mul_rsp.done) begin
          state_nxt = ST_KMIX;
          go_nxt    = 1'b1;
          opnd_nxt  = xorshift(p);
        end
      end
      ST_KMIX: begin
        if (mul_rsp.done) begin
          state_nxt = ST_HMUL;
          go_nxt    = 1'b1;
          opnd_nxt  = h_r ^ p;
          rem_nxt   = rem_r - WORD_BYTES;
        end
      end
      ST_HMUL: begin
        if (mul_rsp.done) begin
          h_nxt = p;
          if (rem_r == '0) begin
            state_nxt = ST_FIN;
            go_nxt    = 1'b1;
            opnd_nxt  = xorshift(p);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PART: begin
        if (mul_rsp.done) begin
          rem_nxt   = '0;
          state_nxt = ST_FIN;
          go_nxt    = 1'b1;
          opnd_nxt  = xorshift(p);
        end
      end
      ST_FIN: begin
        if (mul_rsp.done) begin
          if (!out_valid_r || out_hash.ready) begin
            hash_nxt      = xorshift(p);
            out_valid_nxt = 1'b1;
            h_nxt         = 64'h0;
            state_nxt     = ST_IDLE;
          end else begin
            // output still occupied: park the hash in h
            h_nxt     = xorshift(p);
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_hash.ready) begin
          hash_nxt      = h_r;
          out_valid_nxt = 1'b1;
          h_nxt         = 64'h0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      h_r         <= 64'h0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      h_r         <= h_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    opnd_r <= opnd_nxt;
    word_r <= word_nxt;
    hash_r <= hash_nxt;
  end

  assign in_word.ready       = (state_r == ST_IDLE);
  assign out_hash.valid      = out_valid_r;
  assign out_hash.hash_value = hash_r;

  `MM64_ASSERT_NOW(a_go_idle_unit, go_r, !mul_rsp.busy, "multiply issued while unit busy")
  `MM64_ASSERT_NOW(a_done_in_wait, mul_rsp.done, (state_r == ST_LEN) || (state_r == ST_KMUL) || (state_r == ST_KMIX) || (state_r == ST_HMUL) || (state_r == ST_PART) || (state_r == ST_FIN), "multiply result with no consumer")
  `MM64_ASSERT_NOW(a_full_word, state_r == ST_KMUL, |rem_r[LENGTH_BITS-1:3], "full-word mix with fewer than eight bytes left")
  `MM64_ASSERT_NEXT(a_start_len, in_acc && in_word.start_flag, (state_r == ST_LEN) && go_r, "start word did not launch length multiply")

endmodule
